>>> src/mfpe_pkg.sv
// Shared types, codes and helpers of the prioritized-event motor controller.
package mfpe_pkg;

    localparam int EVENT_W  = 4;
    localparam int STATE_W  = 2;
    localparam int TIMER_W  = 2;
    localparam int DUR_W    = 16;
    localparam int LEVEL_W  = 2;
    localparam int NUM_LEVELS = 4;
    localparam int CFG_IDX_W  = 1;

    localparam logic [STATE_W-1:0] ST_STOP     = 2'd0;
    localparam logic [STATE_W-1:0] ST_STARTING = 2'd1;
    localparam logic [STATE_W-1:0] ST_RUNNING  = 2'd2;
    localparam logic [STATE_W-1:0] ST_FAULT    = 2'd3;

    localparam logic [EVENT_W-1:0] EV_NONE     = 4'd0;
    localparam logic [EVENT_W-1:0] EV_START    = 4'd1;
    localparam logic [EVENT_W-1:0] EV_STOP     = 4'd2;
    localparam logic [EVENT_W-1:0] EV_RESET    = 4'd3;
    localparam logic [EVENT_W-1:0] EV_START_TO = 4'd4;
    localparam logic [EVENT_W-1:0] EV_RUN_TO   = 4'd5;
    localparam logic [EVENT_W-1:0] EV_OVERCUR  = 4'd6;
    localparam logic [EVENT_W-1:0] EV_STALL    = 4'd7;

    localparam logic [TIMER_W-1:0] TMR_NONE  = 2'd0;
    localparam logic [TIMER_W-1:0] TMR_START = 2'd1;
    localparam logic [TIMER_W-1:0] TMR_STOP  = 2'd2;

    localparam logic [1:0] FR_NONE    = 2'd0;
    localparam logic [1:0] FR_OVERCUR = 2'd1;
    localparam logic [1:0] FR_STALL   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_PROTECT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT     = 1'd1;

    localparam logic [DUR_W-1:0] START_PROTECT_RESET = 16'd3000;
    localparam logic [DUR_W-1:0] RUN_LIMIT_RESET     = 16'd60000;

    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 40;

    typedef struct packed {
        logic post_load;
        logic pop_start;
        logic pop_finish;
    } ctrl_t;

    typedef struct packed {
        logic [5:0]         pad;
        logic [DUR_W-1:0]   timer_duration;
        logic [TIMER_W-1:0] run_timer_action;
        logic [TIMER_W-1:0] protect_timer_action;
        logic               alarm;
        logic               motor_drive;
        logic [1:0]         fault_reason;
        logic [STATE_W-1:0] previous_state;
        logic [STATE_W-1:0] motor_state;
        logic [EVENT_W-1:0] taken_event;
        logic               event_taken;
        logic               post_accepted;
    } result_t;

    function automatic logic [LEVEL_W-1:0] level_of(input logic [EVENT_W-1:0] ev);
        logic [LEVEL_W-1:0] lvl;
        case (ev)
            EV_OVERCUR, EV_STALL: lvl = 2'd3;
            EV_STOP:              lvl = 2'd2;
            EV_START, EV_RESET, EV_START_TO, EV_RUN_TO: lvl = 2'd1;
            default:              lvl = 2'd0;
        endcase
        return lvl;
    endfunction

endpackage

>>> src/mfpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mfpe_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/mfpe_ctrl.sv
// Transfer sequencer: accepts an item, waits for the queue read on a run command, presents the result.
module mfpe_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic            s_command,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output mfpe_pkg::ctrl_t ctrl
);
    import mfpe_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_SEND  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_SEND);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next      = state_reg;
        ctrl.post_load  = 1'b0;
        ctrl.pop_start  = 1'b0;
        ctrl.pop_finish = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_command) begin
                        ctrl.pop_start = 1'b1;
                        state_next     = S_FETCH;
                    end else begin
                        ctrl.post_load = 1'b1;
                        state_next     = S_SEND;
                    end
                end
            end
            S_FETCH: begin
                ctrl.pop_finish = 1'b1;
                state_next      = S_SEND;
            end
            S_SEND: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/mfpe_datapath.sv
// Priority queues, motor state machine registers and the result register.
module mfpe_datapath #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mfpe_pkg::ctrl_t                     ctrl,
    input  logic [mfpe_pkg::EVENT_W-1:0]        event_code,
    input  logic                                cfg_we,
    input  logic [mfpe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mfpe_pkg::DUR_W-1:0]          cfg_wdata,
    output mfpe_pkg::result_t                   result
);
    import mfpe_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int RAM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(RAM_DEPTH);

    logic [DUR_W-1:0]   start_protect_reg;
    logic [DUR_W-1:0]   run_limit_reg;

    logic [PTR_W-1:0]   rd_ptr_reg [NUM_LEVELS];
    logic [PTR_W-1:0]   wr_ptr_reg [NUM_LEVELS];
    logic [CNT_W-1:0]   fill_reg   [NUM_LEVELS];
    logic               taken_reg;

    logic [STATE_W-1:0] state_reg, state_next;
    logic [STATE_W-1:0] prior_reg, prior_next;
    logic [1:0]         fault_reg, fault_next;
    logic               drive_reg, drive_next;
    logic               alarm_reg, alarm_next;
    result_t            result_reg;

    logic [LEVEL_W-1:0] post_q, pop_q, qsel;
    logic               any_full;
    logic               post_ok;
    logic [PTR_W-1:0]   ptr_sel, ptr_inc;
    logic [ADDR_W-1:0]  ram_addr;
    logic [EVENT_W-1:0] ram_rdata;
    logic [EVENT_W-1:0] ev;
    logic [TIMER_W-1:0] pa, ra;
    logic [DUR_W-1:0]   dur;
    logic               stop_f, fault_f;
    logic [1:0]         reason;

    assign post_q = level_of(event_code);

    always_comb begin
        pop_q    = 2'd0;
        any_full = 1'b0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (fill_reg[i] != '0) begin
                pop_q    = LEVEL_W'(i);
                any_full = 1'b1;
            end
        end
    end

    assign qsel     = ctrl.pop_start ? pop_q : post_q;
    assign ptr_sel  = ctrl.pop_start ? rd_ptr_reg[qsel] : wr_ptr_reg[qsel];
    assign ptr_inc  = (ptr_sel == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_sel + 1'b1;
    assign ram_addr = ADDR_W'(qsel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr_sel);
    assign post_ok  = (event_code != EV_NONE) && (fill_reg[qsel] != CNT_W'(QUEUE_DEPTH));

    mfpe_ram #(
        .WIDTH (EVENT_W),
        .DEPTH (RAM_DEPTH)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (ctrl.post_load && post_ok),
        .waddr (ram_addr),
        .wdata (event_code),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                rd_ptr_reg[i] <= '0;
                wr_ptr_reg[i] <= '0;
                fill_reg[i]   <= '0;
            end
            taken_reg <= 1'b0;
        end else if (ctrl.post_load && post_ok) begin
            wr_ptr_reg[qsel] <= ptr_inc;
            fill_reg[qsel]   <= fill_reg[qsel] + 1'b1;
        end else if (ctrl.pop_start) begin
            taken_reg <= any_full;
            if (any_full) begin
                rd_ptr_reg[qsel] <= ptr_inc;
                fill_reg[qsel]   <= fill_reg[qsel] - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_protect_reg <= START_PROTECT_RESET;
            run_limit_reg     <= RUN_LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_START_PROTECT: start_protect_reg <= cfg_wdata;
                CFG_RUN_LIMIT:     run_limit_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign ev = taken_reg ? ram_rdata : EV_NONE;

    always_comb begin
        state_next = state_reg;
        prior_next = prior_reg;
        fault_next = fault_reg;
        drive_next = drive_reg;
        alarm_next = alarm_reg;
        pa         = TMR_NONE;
        ra         = TMR_NONE;
        dur        = '0;
        stop_f     = 1'b0;
        fault_f    = 1'b0;
        reason     = FR_NONE;
        if (taken_reg) begin
            unique case (state_reg)
                ST_STOP: begin
                    if (ev == EV_START) begin
                        drive_next = 1'b1;
                        pa         = TMR_START;
                        dur        = start_protect_reg;
                        prior_next = state_reg;
                        state_next = ST_STARTING;
                        fault_next = FR_NONE;
                    end
                end
                ST_STARTING: begin
                    if (ev == EV_OVERCUR) begin
                        fault_f = 1'b1;
                        reason  = FR_OVERCUR;
                    end else if (ev == EV_STALL) begin
                        fault_f = 1'b1;
                        reason  = FR_STALL;
                    end else if (ev == EV_START_TO) begin
                        pa         = TMR_STOP;
                        ra         = TMR_START;
                        dur        = run_limit_reg;
                        prior_next = state_reg;
                        state_next = ST_RUNNING;
                    end else if (ev == EV_STOP) begin
                        stop_f = 1'b1;
                    end
                end
                ST_RUNNING: begin
                    if (ev == EV_OVERCUR) begin
                        fault_f = 1'b1;
                        reason  = FR_OVERCUR;
                    end else if (ev == EV_STALL) begin
                        fault_f = 1'b1;
                        reason  = FR_STALL;
                    end else if (ev == EV_STOP || ev == EV_RUN_TO) begin
                        stop_f = 1'b1;
                    end
                end
                ST_FAULT: begin
                    if (ev == EV_RESET) begin
                        alarm_next = 1'b0;
                        fault_next = FR_NONE;
                        stop_f     = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (stop_f || fault_f) begin
            drive_next = 1'b0;
            pa         = TMR_STOP;
            ra         = TMR_STOP;
            prior_next = state_reg;
            state_next = fault_f ? ST_FAULT : ST_STOP;
        end
        if (fault_f) begin
            fault_next = reason;
            alarm_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_STOP;
            prior_reg <= ST_STOP;
            fault_reg <= FR_NONE;
            drive_reg <= 1'b0;
            alarm_reg <= 1'b0;
        end else if (ctrl.pop_finish) begin
            state_reg <= state_next;
            prior_reg <= prior_next;
            fault_reg <= fault_next;
            drive_reg <= drive_next;
            alarm_reg <= alarm_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.post_load) begin
            result_reg.pad                  <= '0;
            result_reg.timer_duration       <= '0;
            result_reg.run_timer_action     <= TMR_NONE;
            result_reg.protect_timer_action <= TMR_NONE;
            result_reg.alarm                <= alarm_reg;
            result_reg.motor_drive          <= drive_reg;
            result_reg.fault_reason         <= fault_reg;
            result_reg.previous_state       <= prior_reg;
            result_reg.motor_state          <= state_reg;
            result_reg.taken_event          <= EV_NONE;
            result_reg.event_taken          <= 1'b0;
            result_reg.post_accepted        <= post_ok;
        end else if (ctrl.pop_finish) begin
            result_reg.pad                  <= '0;
            result_reg.timer_duration       <= dur;
            result_reg.run_timer_action     <= ra;
            result_reg.protect_timer_action <= pa;
            result_reg.alarm                <= alarm_next;
            result_reg.motor_drive          <= drive_next;
            result_reg.fault_reason         <= fault_next;
            result_reg.previous_state       <= prior_next;
            result_reg.motor_state          <= state_next;
            result_reg.taken_event          <= ev;
            result_reg.event_taken          <= taken_reg;
            result_reg.post_accepted        <= 1'b0;
        end
    end

    assign result = result_reg;

endmodule

>>> src/motor_fsm_priority_events.sv
// Top level of the motor protection controller with four prioritized event queues.
// One item is taken at a time. A post transfer (s_tuser = 0) shows its result in the
// cycle after acceptance; a run transfer (s_tuser = 1) shows it after the registered
// read of the shared queue RAM and then the result register. After the result
// transfer the block is ready again in the next cycle. Event codes are queued per
// priority level in one RAM of 4 x QUEUE_DEPTH entries; a full level refuses the
// event. Configuration writes apply at once and are meant for idle periods.
module motor_fsm_priority_events #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // tdata: event_code[3:0], zero padding
    input  logic [mfpe_pkg::TDATA_IN_W-1:0]     s_tdata,
    // tuser: command
    input  logic                                s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: post_accepted, event_taken, taken_event[3:0], motor_state[1:0],
    // previous_state[1:0], fault_reason[1:0], motor_drive, alarm,
    // protect_timer_action[1:0], run_timer_action[1:0], timer_duration[15:0], padding
    output logic [mfpe_pkg::TDATA_OUT_W-1:0]    m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [mfpe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mfpe_pkg::DUR_W-1:0]          cfg_wdata
);
    import mfpe_pkg::*;

    ctrl_t   ctrl;
    result_t result;

    mfpe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_command (s_tuser),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .ctrl      (ctrl)
    );

    mfpe_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .event_code (s_tdata[EVENT_W-1:0]),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .result     (result)
    );

    assign m_tdata = result;

endmodule
